@@ rtl/core/bpp_pkg.sv @@
// Shared types, codes and constants of the pressure sensor poller.
`default_nettype none
package bpp_pkg;

  localparam int unsigned TimeBitsDefault = 32;
  localparam int unsigned StampW          = 32;
  localparam int unsigned PayloadW        = 19;
  localparam int unsigned CfgDataW        = 5;
  localparam int unsigned ResDepth        = 4;

  localparam logic [7:0] CmdReg  = 8'hF4;
  localparam logic [7:0] DataReg = 8'hF6;
  localparam logic [7:0] CmdTemp = 8'h2E;
  localparam logic [7:0] CmdPres = 8'h34;

  localparam logic [1:0] OsReset       = 2'd2;
  localparam logic [4:0] TempWaitReset = 5'd5;

  typedef enum logic [1:0] {
    PH_START_TEMP = 2'd0,
    PH_READ_TEMP  = 2'd1,
    PH_START_PRES = 2'd2,
    PH_READ_PRES  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_TEMP = 2'd1,
    KIND_PRES = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_OVERSAMPLING   = 2'd0,
    CFG_TEMP_WAIT      = 2'd1,
    CFG_SENSOR_PRESENT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [StampW-1:0] elapsed_ms;
    logic [7:0]        read_msb;
    logic [7:0]        read_lsb;
    logic [7:0]        read_xlsb;
    logic              read_ok;
  } poll_t;

  typedef struct packed {
    logic [1:0]          result_kind;
    logic [7:0]          reg_address;
    logic [PayloadW-1:0] payload;
    logic [StampW-1:0]   stamp_ms;
    logic                last_of_poll;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [4:0] pres_wait(input logic [1:0] os);
    logic [4:0] w;
    case (os)
      2'd0:    w = 5'd5;
      2'd1:    w = 5'd8;
      2'd2:    w = 5'd14;
      default: w = 5'd26;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] pres_cmd(input logic [1:0] os);
    return {os, 6'd0} + CmdPres;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/bpp_if.sv @@
// Handshake channels for polls and for results.
`default_nettype none
interface bpp_in_if;
  logic                         valid;
  logic                         ready;
  logic [bpp_pkg::StampW-1:0]   elapsed_ms;
  logic [7:0]                   read_msb;
  logic [7:0]                   read_lsb;
  logic [7:0]                   read_xlsb;
  logic                         read_ok;

  modport source (output valid, elapsed_ms, read_msb, read_lsb, read_xlsb, read_ok,
                  input ready);
  modport sink (input valid, elapsed_ms, read_msb, read_lsb, read_xlsb, read_ok,
                output ready);
endinterface

interface bpp_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   result_kind;
  logic [7:0]                   reg_address;
  logic [bpp_pkg::PayloadW-1:0] payload;
  logic [bpp_pkg::StampW-1:0]   stamp_ms;
  logic                         last_of_poll;

  modport source (output valid, result_kind, reg_address, payload, stamp_ms, last_of_poll,
                  input ready);
  modport sink (input valid, result_kind, reg_address, payload, stamp_ms, last_of_poll,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/baro_temp_pressure_poller_unit.sv @@
// Top level of the barometric pressure and temperature polling sequencer.
// Each poll transfer is registered and evaluated against the four-phase schedule once the
// queue has room for two more results; its zero, one or two results are queued in a
// four-entry result queue, whose registered head drives the output. A poll is taken every
// cycle while the queue has room for two more results; results leave at one per cycle
// while the output is ready, so a run of two-result polls is paced by the queue's single
// output port. The result side stalling never blocks a poll until the queue fills.
`default_nettype none
module baro_temp_pressure_poller_unit #(
  parameter int unsigned TIME_BITS = bpp_pkg::TimeBitsDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [bpp_pkg::CfgDataW-1:0] cfg_wdata_i,
  bpp_in_if.sink                            in_i,
  bpp_out_if.source                         out_o
);

  bpp_pkg::push_t push;
  logic           space;

  bpp_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .space_i     (space),
    .push_o      (push)
  );

  bpp_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/bpp_core.sv @@
// Poll input register, configuration registers and the four-phase sequencer.
`default_nettype none
module bpp_core #(
  parameter int unsigned TIME_BITS = bpp_pkg::TimeBitsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [bpp_pkg::CfgDataW-1:0] cfg_wdata_i,
  bpp_in_if.sink               in_i,
  input  wire logic            space_i,
  output bpp_pkg::push_t       push_o
);

  localparam int unsigned TimeW =
      (TIME_BITS < bpp_pkg::StampW) ? TIME_BITS : bpp_pkg::StampW;

  logic              s_valid_q;
  bpp_pkg::poll_t    s_q;
  logic [1:0]        os_q;
  logic [4:0]        temp_wait_q;
  logic              present_q;
  bpp_pkg::phase_e   phase_q, phase_d;
  logic [TimeW-1:0]  last_q, last_d;
  logic [4:0]        wait_q, wait_d;

  logic              fire;
  logic              in_xfer;
  logic              due;
  logic              act;
  logic [TimeW-1:0]  now;
  logic [TimeW-1:0]  gap;
  bpp_pkg::push_t    push;
  logic [23:0]       raw;
  logic [bpp_pkg::PayloadW-1:0] pres_val;

  assign fire        = s_valid_q && space_i;
  assign in_i.ready  = !s_valid_q || space_i;
  assign in_xfer     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s_valid_q <= 1'b1;
    end else if (fire) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s_q.elapsed_ms <= in_i.elapsed_ms;
      s_q.read_msb   <= in_i.read_msb;
      s_q.read_lsb   <= in_i.read_lsb;
      s_q.read_xlsb  <= in_i.read_xlsb;
      s_q.read_ok    <= in_i.read_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      os_q        <= bpp_pkg::OsReset;
      temp_wait_q <= bpp_pkg::TempWaitReset;
      present_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpp_pkg::CFG_OVERSAMPLING:   os_q        <= cfg_wdata_i[1:0];
        bpp_pkg::CFG_TEMP_WAIT:      temp_wait_q <= cfg_wdata_i[4:0];
        bpp_pkg::CFG_SENSOR_PRESENT: present_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign now = s_q.elapsed_ms[TimeW-1:0];
  assign gap = now - last_q;
  assign due = (now > last_q) && (gap > TimeW'(wait_q));
  assign act = fire && present_q && due;
  assign raw = {s_q.read_msb, s_q.read_lsb, s_q.read_xlsb};

  always_comb begin
    case (os_q)
      2'd0:    pres_val = bpp_pkg::PayloadW'(raw >> 8);
      2'd1:    pres_val = bpp_pkg::PayloadW'(raw >> 7);
      2'd2:    pres_val = bpp_pkg::PayloadW'(raw >> 6);
      default: pres_val = bpp_pkg::PayloadW'(raw >> 5);
    endcase
  end

  always_comb begin
    push                 = '0;
    push.r0.stamp_ms     = s_q.elapsed_ms;
    push.r1.stamp_ms     = s_q.elapsed_ms;
    push.r0.result_kind  = bpp_pkg::KIND_CMD;
    push.r0.reg_address  = bpp_pkg::CmdReg;
    push.r1.result_kind  = bpp_pkg::KIND_CMD;
    push.r1.reg_address  = bpp_pkg::CmdReg;
    push.r1.payload      = bpp_pkg::PayloadW'(bpp_pkg::pres_cmd(os_q));
    push.r1.last_of_poll = 1'b1;
    phase_d              = phase_q;
    wait_d               = wait_q;
    last_d               = last_q;
    if (act) begin
      last_d = now;
      unique case (phase_q)
        bpp_pkg::PH_START_TEMP: begin
          push.count      = 2'd1;
          push.r0.payload = bpp_pkg::PayloadW'(bpp_pkg::CmdTemp);
          phase_d         = bpp_pkg::PH_READ_TEMP;
          wait_d          = temp_wait_q;
        end
        bpp_pkg::PH_READ_TEMP: begin
          push.count          = 2'd2;
          push.r0.result_kind = bpp_pkg::KIND_TEMP;
          push.r0.reg_address = bpp_pkg::DataReg;
          push.r0.payload     = bpp_pkg::PayloadW'({s_q.read_msb, s_q.read_lsb});
          phase_d             = bpp_pkg::PH_READ_PRES;
          wait_d              = bpp_pkg::pres_wait(os_q);
        end
        bpp_pkg::PH_START_PRES: begin
          push.count      = 2'd1;
          push.r0.payload = bpp_pkg::PayloadW'(bpp_pkg::pres_cmd(os_q));
          phase_d         = bpp_pkg::PH_READ_PRES;
          wait_d          = bpp_pkg::pres_wait(os_q);
        end
        default: begin
          push.count          = s_q.read_ok ? 2'd1 : 2'd0;
          push.r0.result_kind = bpp_pkg::KIND_PRES;
          push.r0.reg_address = bpp_pkg::DataReg;
          push.r0.payload     = pres_val;
          phase_d             = bpp_pkg::PH_START_TEMP;
          wait_d              = 5'd0;
        end
      endcase
    end
    push.r0.last_of_poll = (push.count == 2'd1);
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bpp_pkg::PH_START_TEMP;
      last_q  <= '0;
      wait_q  <= '0;
    end else begin
      phase_q <= phase_d;
      last_q  <= last_d;
      wait_q  <= wait_d;
    end
  end

  a_two_only_from_temp_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count == 2'd2 |-> act && phase_q == bpp_pkg::PH_READ_TEMP)
    else $error("two results outside temperature read");

  a_pres_read_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act && phase_q == bpp_pkg::PH_READ_PRES |=> phase_q == bpp_pkg::PH_START_TEMP && wait_q == 5'd0)
    else $error("pressure read did not return to start");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !act |=> $stable(phase_q) && $stable(last_q) && $stable(wait_q))
    else $error("state changed without a due poll");

endmodule
`default_nettype wire

@@ rtl/core/bpp_res_fifo.sv @@
// Result queue: takes up to two results per cycle, hands out one per transfer.
`default_nettype none
module bpp_res_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  bpp_pkg::push_t   push_i,
  output logic             space_o,
  bpp_out_if.source        out_o
);

  localparam int unsigned Depth = bpp_pkg::ResDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  bpp_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             pop;
  logic [PtrW-1:0]  wr_next;
  bpp_pkg::result_t head;

  assign pop     = out_o.valid && out_o.ready;
  assign space_o = count_q <= CntW'(Depth - 2);
  assign wr_next = wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.count);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_q + CntW'(push_i.count) - CntW'(pop);
    end
  end

  assign head               = mem_q[rd_ptr_q];
  assign out_o.valid        = count_q != '0;
  assign out_o.result_kind  = head.result_kind;
  assign out_o.reg_address  = head.reg_address;
  assign out_o.payload      = head.payload;
  assign out_o.stamp_ms     = head.stamp_ms;
  assign out_o.last_of_poll = head.last_of_poll;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> count_q <= CntW'(Depth - 2))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result count out of range");

endmodule
`default_nettype wire

@@ bench/baro_temp_pressure_poller_unit_test.sv @@
// Self-checking bench of the pressure sensor poller against a local schedule model.
`timescale 1ns / 100ps
module baro_temp_pressure_poller_unit_test;

  localparam logic [1:0]  CfgIdxUnused = 2'd3;
  localparam logic [19:0] PresWaitTab  = {5'd26, 5'd14, 5'd8, 5'd5};
  localparam int          SettleCycles = 8;
  localparam int          StallLimit   = 2000;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [1:0]                   cfg_idx_i;
  logic [bpp_pkg::CfgDataW-1:0] cfg_wdata_i;

  bpp_in_if  poll_if ();
  bpp_out_if res_if ();

  baro_temp_pressure_poller_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (poll_if),
    .out_o      (res_if)
  );

  always #6 clk_i = ~clk_i;

  logic [1:0]  os_cfg        = bpp_pkg::OsReset;
  logic [4:0]  temp_wait_cfg = bpp_pkg::TempWaitReset;
  logic        present_cfg   = 1'b1;

  bpp_pkg::phase_e sched_phase  = bpp_pkg::PH_START_TEMP;
  logic [31:0]     last_act_ms  = '0;
  logic [4:0]      conv_wait_ms = '0;

  bpp_pkg::poll_t   pending_polls_q[$];
  bpp_pkg::result_t sensor_results_q[$];
  bpp_pkg::poll_t   cur_poll;
  logic [31:0]      gen_ms;
  int               send_gap;
  int               recv_stall;
  int               send_idle_max;
  int               recv_idle_max;
  int               idle_cycles;
  int               mismatch_cnt;

  function automatic bpp_pkg::result_t make_result(input bpp_pkg::kind_e kind,
                                                   input logic [7:0] addr,
                                                   input logic [23:0] value,
                                                   input logic [31:0] stamp);
    bpp_pkg::result_t r;
    r.result_kind  = kind;
    r.reg_address  = addr;
    r.payload      = value[bpp_pkg::PayloadW-1:0];
    r.stamp_ms     = stamp;
    r.last_of_poll = 1'b0;
    return r;
  endfunction

  task automatic predict_sensor_results(input bpp_pkg::poll_t p);
    bpp_pkg::result_t res[$];
    bpp_pkg::result_t tail;
    logic [7:0]       pres_cmd_byte;
    logic [23:0]      raw;
    pres_cmd_byte = bpp_pkg::CmdPres + {os_cfg, 6'd0};
    raw = {p.read_msb, p.read_lsb, p.read_xlsb};
    if (!present_cfg) return;
    if (!(p.elapsed_ms > last_act_ms && p.elapsed_ms - last_act_ms > {27'd0, conv_wait_ms}))
      return;
    case (sched_phase) inside
      bpp_pkg::PH_START_TEMP: begin
        res.push_back(make_result(bpp_pkg::KIND_CMD, bpp_pkg::CmdReg,
                                  {16'd0, bpp_pkg::CmdTemp}, p.elapsed_ms));
        sched_phase  = bpp_pkg::PH_READ_TEMP;
        conv_wait_ms = temp_wait_cfg;
      end
      bpp_pkg::PH_READ_TEMP, bpp_pkg::PH_START_PRES: begin
        if (sched_phase == bpp_pkg::PH_READ_TEMP)
          res.push_back(make_result(bpp_pkg::KIND_TEMP, bpp_pkg::DataReg,
                                    {8'd0, p.read_msb, p.read_lsb}, p.elapsed_ms));
        res.push_back(make_result(bpp_pkg::KIND_CMD, bpp_pkg::CmdReg,
                                  {16'd0, pres_cmd_byte}, p.elapsed_ms));
        sched_phase  = bpp_pkg::PH_READ_PRES;
        conv_wait_ms = PresWaitTab[os_cfg*5 +: 5];
      end
      default: begin
        if (p.read_ok)
          res.push_back(make_result(bpp_pkg::KIND_PRES, bpp_pkg::DataReg,
                                    raw >> (4'd8 - {2'd0, os_cfg}), p.elapsed_ms));
        sched_phase  = bpp_pkg::PH_START_TEMP;
        conv_wait_ms = '0;
      end
    endcase
    last_act_ms = p.elapsed_ms;
    if (res.size() > 0) begin
      tail = res.pop_back();
      tail.last_of_poll = 1'b1;
      res.push_back(tail);
    end
    foreach (res[k]) sensor_results_q.push_back(res[k]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: result mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  task automatic push_poll(input logic [31:0] ms, input logic [7:0] msb, input logic [7:0] lsb,
                           input logic [7:0] xlsb, input logic ok);
    bpp_pkg::poll_t p;
    p.elapsed_ms = ms;
    p.read_msb   = msb;
    p.read_lsb   = lsb;
    p.read_xlsb  = xlsb;
    p.read_ok    = ok;
    pending_polls_q.push_back(p);
  endtask

  task automatic push_random_poll();
    int          sel;
    logic [32:0] t;
    sel = $urandom_range(0, 99);
    if (sel < 60)
      t = {1'b0, gen_ms} + 33'($urandom_range(0, 8));
    else if (sel < 85)
      t = {1'b0, gen_ms} + 33'($urandom_range(9, 40));
    else if (sel < 95)
      t = {1'b0, 32'($urandom_range(0, gen_ms))};
    else
      t = {1'b0, gen_ms} + 33'($urandom_range(41, 1 << 20));
    if (t > 33'h0_FFFF_FFFF) t = 33'h0_FFFF_FFFF;
    push_poll(t[31:0], 8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(0, 99) < 85);
    if (t[31:0] > gen_ms) gen_ms = t[31:0];
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [bpp_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      bpp_pkg::CFG_OVERSAMPLING:   os_cfg = data[1:0];
      bpp_pkg::CFG_TEMP_WAIT:      temp_wait_cfg = data[4:0];
      bpp_pkg::CFG_SENSOR_PRESENT: present_cfg = data[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (pending_polls_q.size() != 0 || poll_if.valid || sensor_results_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // poll driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_if.valid <= 1'b0;
    end else begin
      if (poll_if.valid && poll_if.ready) predict_sensor_results(cur_poll);
      if (!poll_if.valid || poll_if.ready) begin
        if (send_gap > 0 || pending_polls_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          poll_if.valid <= 1'b0;
        end else begin
          cur_poll = pending_polls_q.pop_front();
          poll_if.valid      <= 1'b1;
          poll_if.elapsed_ms <= cur_poll.elapsed_ms;
          poll_if.read_msb   <= cur_poll.read_msb;
          poll_if.read_lsb   <= cur_poll.read_lsb;
          poll_if.read_xlsb  <= cur_poll.read_xlsb;
          poll_if.read_ok    <= cur_poll.read_ok;
          send_gap = int'($urandom_range(0, send_idle_max));
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    bpp_pkg::result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (sensor_results_q.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(res_if.payload), '0);
        end else begin
          want = sensor_results_q.pop_front();
          if (res_if.result_kind !== want.result_kind)
            report_mismatch("result_kind", 32'(res_if.result_kind), 32'(want.result_kind));
          if (res_if.reg_address !== want.reg_address)
            report_mismatch("reg_address", 32'(res_if.reg_address), 32'(want.reg_address));
          if (res_if.payload !== want.payload)
            report_mismatch("payload", 32'(res_if.payload), 32'(want.payload));
          if (res_if.stamp_ms !== want.stamp_ms)
            report_mismatch("stamp_ms", res_if.stamp_ms, want.stamp_ms);
          if (res_if.last_of_poll !== want.last_of_poll)
            report_mismatch("last_of_poll", 32'(res_if.last_of_poll), 32'(want.last_of_poll));
        end
        recv_stall = int'($urandom_range(0, recv_idle_max));
      end
      if (recv_stall > 0) begin
        recv_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((poll_if.valid && poll_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int seg;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_wdata_i        = '0;
    poll_if.valid      = 1'b0;
    poll_if.elapsed_ms = '0;
    poll_if.read_msb   = '0;
    poll_if.read_lsb   = '0;
    poll_if.read_xlsb  = '0;
    poll_if.read_ok    = 1'b0;
    res_if.ready       = 1'b0;
    send_gap           = 0;
    recv_stall         = 0;
    send_idle_max      = 4;
    recv_idle_max      = 4;
    idle_cycles        = 0;
    mismatch_cnt       = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_poll(32'd0,  8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd1,  8'h11, 8'h22, 8'h33, 1'b1);
    push_poll(32'd6,  8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd7,  8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_poll(32'd21, 8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd22, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_poll(32'd22, 8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd5,  8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd23, 8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd29, 8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd44, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_poll(32'd45, 8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd51, 8'hA5, 8'h5A, 8'h00, 1'b1);
    push_poll(32'd66, 8'h00, 8'h00, 8'h00, 1'b1);
    settle();
    write_reg(bpp_pkg::CFG_OVERSAMPLING, 5'b11100);
    write_reg(bpp_pkg::CFG_TEMP_WAIT, 5'd0);
    push_poll(32'd67, 8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd68, 8'h5A, 8'hA5, 8'h00, 1'b1);
    push_poll(32'd74, 8'h12, 8'h34, 8'h56, 1'b1);
    settle();
    write_reg(bpp_pkg::CFG_OVERSAMPLING, 5'b11111);
    write_reg(bpp_pkg::CFG_TEMP_WAIT, 5'd31);
    push_poll(32'd75, 8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd106, 8'h00, 8'h00, 8'h00, 1'b1);
    push_poll(32'd107, 8'h80, 8'h01, 8'h00, 1'b1);
    settle();
    write_reg(bpp_pkg::CFG_OVERSAMPLING, 5'd1);
    push_poll(32'd134, 8'h80, 8'h00, 8'h01, 1'b1);
    settle();
    write_reg(bpp_pkg::CFG_SENSOR_PRESENT, 5'b11110);
    write_reg(CfgIdxUnused, 5'b10101);
    push_poll(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_poll(32'd200, 8'h00, 8'h00, 8'h00, 1'b1);
    settle();
    write_reg(bpp_pkg::CFG_SENSOR_PRESENT, 5'b00001);
    push_poll(32'd135, 8'h00, 8'h00, 8'h00, 1'b1);
    gen_ms = 32'd135;

    for (seg = 0; seg < 10; seg++) begin
      settle();
      write_reg(bpp_pkg::CFG_OVERSAMPLING, {3'($urandom), 2'(seg)});
      write_reg(bpp_pkg::CFG_TEMP_WAIT, (seg == 0) ? 5'd0 : (seg == 1) ? 5'd31 : 5'($urandom));
      if (seg == 5) begin
        write_reg(bpp_pkg::CFG_SENSOR_PRESENT, 5'd0);
        repeat (30) push_random_poll();
        settle();
      end
      write_reg(bpp_pkg::CFG_SENSOR_PRESENT, 5'd1);
      if (seg == 9) begin
        gen_ms = 32'hFFFF_FC00;
      end else if (gen_ms < 32'(seg) * 32'h1800_0000) begin
        gen_ms = 32'(seg) * 32'h1800_0000 + 32'($urandom_range(0, 32'h0FFF_FFFF));
      end
      send_idle_max = (seg % 3 == 0) ? 0 : 4;
      recv_idle_max = (seg % 4 == 1) ? 0 : 4;
      repeat (150) push_random_poll();
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
